FILE: src/dtc_pkg.sv
// shared constants and types for the depth-to-color pixel registration block
// composite projection coefficients, color intrinsics, frame defaults
// no dependencies
`default_nettype none

package dtc_pkg;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    // composite affine form Q_k = d*(A_k*c + B_k*r + C_k) + D_k, units of 1e-3
    localparam logic signed [31:0] COEF_A0 = 32'sd572216;
    localparam logic signed [31:0] COEF_A1 = 32'sd4502;
    localparam logic signed [31:0] COEF_A2 = 32'sd544;
    localparam logic signed [31:0] COEF_B0 = -32'sd4498;
    localparam logic signed [31:0] COEF_B1 = 32'sd572096;
    localparam logic signed [31:0] COEF_B2 = -32'sd2998;
    localparam logic signed [31:0] COEF_C0 = -32'sd182263383;
    localparam logic signed [31:0] COEF_C1 = -32'sd143100361;
    localparam logic signed [31:0] COEF_C2 = 32'sd327960071;
    localparam logic signed [47:0] COEF_D0 = -48'sd8707800061;
    localparam logic signed [47:0] COEF_D1 = 48'sd104528940;
    localparam logic signed [47:0] COEF_D2 = 48'sd684411783;

    // color focal lengths in milli-pixels, halved (the factor 8 of 4096/1000 cancels)
    localparam logic [18:0] FX_HALF = 19'd267827;
    localparam logic [18:0] FY_HALF = 19'd267789;

    // color principal point in Q12
    localparam logic signed [27:0] CX_Q12 = 28'sd1309603;
    localparam logic signed [27:0] CY_Q12 = 28'sd978262;

    // divider geometry
    localparam int DIV_STEPS = 25;  // quotient bits, top bit flags overflow
    localparam int REM_W     = 80;  // dividend and remainder width
    localparam int DEN_W     = 56;  // scaled denominator width

    typedef struct packed {
        logic ok;
        logic sgn_x;
        logic sgn_y;
    } side_t;

endpackage : dtc_pkg

`default_nettype wire

FILE: src/depth_to_color_pixel_registration.sv
// top level of the depth-to-color pixel registration pipeline
// depends on dtc_pkg for coefficients, intrinsics and the side-band type
// no submodules
`default_nettype none

// Maps one depth pixel (column, row, depth in mm) to color-image sampling
// coordinates in signed Q4, one item per clock while m_tready does not stall
// the output. The pipeline is 31 stages deep, and a new item can enter in
// every cycle in which it advances. Most of those stages belong to the two
// restoring dividers (25 stages each, one quotient bit per stage) that form
// fx*X/Z and fy*Y/Z in parallel. A stall on m_tready freezes the whole
// pipeline; s_tready follows from it combinationally. Pixels outside the
// frame, and points with a non-positive projected depth, come out as zero
// coordinates with tuser low. Coordinates beyond the 16-bit range saturate.
module depth_to_color_pixel_registration #(
    parameter int FRAME_WIDTH  = dtc_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = dtc_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // pixel_column[9:0], pixel_row[19:10], depth_raw[35:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // map_x_q4[15:0], map_y_q4[31:16]
    output logic             m_tuser    // coord_valid
);

    localparam int NS = dtc_pkg::DIV_STEPS;
    localparam int RW = dtc_pkg::REM_W;
    localparam int DW = dtc_pkg::DEN_W;

    // global advance: the whole pipeline moves when the output is free
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // input unpack
    logic [9:0]  in_col;
    logic [9:0]  in_row;
    logic [15:0] in_dep;
    logic        in_frame;
    assign in_col   = s_tdata[9:0];
    assign in_row   = s_tdata[19:10];
    assign in_dep   = s_tdata[35:20];
    assign in_frame = ({1'b0, in_col} < 11'(FRAME_WIDTH)) &&
                      ({1'b0, in_row} < 11'(FRAME_HEIGHT));

    // stage 1: per-pixel linear sums
    logic                     v1_reg;
    logic                     f1_reg;
    logic [15:0]              d1_reg;
    logic signed [31:0]       s1_reg [3];
    logic signed [31:0]       s_next [3];
    logic signed [31:0]       col_s;
    logic signed [31:0]       row_s;

    assign col_s = $signed({22'd0, in_col});
    assign row_s = $signed({22'd0, in_row});

    always_comb begin
        s_next[0] = dtc_pkg::COEF_A0 * col_s + dtc_pkg::COEF_B0 * row_s + dtc_pkg::COEF_C0;
        s_next[1] = dtc_pkg::COEF_A1 * col_s + dtc_pkg::COEF_B1 * row_s + dtc_pkg::COEF_C1;
        s_next[2] = dtc_pkg::COEF_A2 * col_s + dtc_pkg::COEF_B2 * row_s + dtc_pkg::COEF_C2;
    end

    // stage 2: scale by depth and add translation
    logic                     v2_reg;
    logic                     f2_reg;
    logic signed [47:0]       q2_reg [3];
    logic signed [47:0]       q_next [3];
    logic signed [47:0]       dep_s;

    assign dep_s = $signed({32'd0, d1_reg});

    always_comb begin
        q_next[0] = dep_s * 48'(s1_reg[0]) + dtc_pkg::COEF_D0;
        q_next[1] = dep_s * 48'(s1_reg[1]) + dtc_pkg::COEF_D1;
        q_next[2] = dep_s * 48'(s1_reg[2]) + dtc_pkg::COEF_D2;
    end

    // stage 3: validity, signs and magnitudes
    logic                     v3_reg;
    dtc_pkg::side_t           sd3_reg;
    logic [46:0]              mx3_reg;
    logic [46:0]              my3_reg;
    logic [46:0]              den3_reg;
    logic [47:0]              abs_x;
    logic [47:0]              abs_y;

    assign abs_x = q2_reg[0][47] ? 48'(-q2_reg[0]) : 48'(q2_reg[0]);
    assign abs_y = q2_reg[1][47] ? 48'(-q2_reg[1]) : 48'(q2_reg[1]);

    // stage 4: partial products of numerators, scaled denominator
    logic                     v4_reg;
    dtc_pkg::side_t           sd4_reg;
    logic [42:0]              lox4_reg;
    logic [41:0]              hix4_reg;
    logic [42:0]              loy4_reg;
    logic [41:0]              hiy4_reg;
    logic [DW-1:0]            dd4_reg;
    logic [DW-1:0]            dd_next;

    // times 125 = 128 - 2 - 1
    assign dd_next = (DW'(den3_reg) << 7) - (DW'(den3_reg) << 1) - DW'(den3_reg);

    // divider pipeline, index 0 loaded from stage 4
    logic                     vd_reg  [NS+1];
    dtc_pkg::side_t           sdd_reg [NS+1];
    logic [DW-1:0]            ddd_reg [NS+1];
    logic [RW-1:0]            rx_reg  [NS+1];
    logic [RW-1:0]            ry_reg  [NS+1];
    logic [NS-1:0]            qx_reg  [NS+1];
    logic [NS-1:0]            qy_reg  [NS+1];
    logic [RW:0]              sub_x   [NS];
    logic [RW:0]              sub_y   [NS];

    always_comb begin
        for (int j = 0; j < NS; j++) begin
            sub_x[j] = {1'b0, rx_reg[j]} - {1'b0, RW'(ddd_reg[j]) << (NS - 1 - j)};
            sub_y[j] = {1'b0, ry_reg[j]} - {1'b0, RW'(ddd_reg[j]) << (NS - 1 - j)};
        end
    end

    // output stage: add principal point, round to Q4, saturate
    logic [NS-1:0]            qfx;
    logic [NS-1:0]            qfy;
    logic signed [27:0]       tot_x;
    logic signed [27:0]       tot_y;
    logic signed [19:0]       r4x;
    logic signed [19:0]       r4y;
    logic [15:0]              sat_x;
    logic [15:0]              sat_y;
    logic [31:0]              odata_next;

    // top quotient bit means the quotient is out of range: pin to 2^24
    assign qfx = qx_reg[NS][NS-1] ? NS'(1) << (NS - 1) : qx_reg[NS];
    assign qfy = qy_reg[NS][NS-1] ? NS'(1) << (NS - 1) : qy_reg[NS];

    always_comb begin
        tot_x = (sdd_reg[NS].sgn_x ? -$signed(28'(qfx)) : $signed(28'(qfx)))
                + dtc_pkg::CX_Q12 + 28'sd128;
        tot_y = (sdd_reg[NS].sgn_y ? -$signed(28'(qfy)) : $signed(28'(qfy)))
                + dtc_pkg::CY_Q12 + 28'sd128;
        r4x   = 20'(tot_x >>> 8);
        r4y   = 20'(tot_y >>> 8);
        if (r4x > 20'sd32767) begin
            sat_x = 16'h7fff;
        end else if (r4x < -20'sd32768) begin
            sat_x = 16'h8000;
        end else begin
            sat_x = r4x[15:0];
        end
        if (r4y > 20'sd32767) begin
            sat_y = 16'h7fff;
        end else if (r4y < -20'sd32768) begin
            sat_y = 16'h8000;
        end else begin
            sat_y = r4y[15:0];
        end
        odata_next = sdd_reg[NS].ok ? {sat_y, sat_x} : 32'd0;
    end

    logic        mv_reg;
    logic [31:0] md_reg;
    logic        mu_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int j = 0; j <= NS; j++) begin
                vd_reg[j] <= 1'b0;
            end
            mv_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int j = 0; j < NS; j++) begin
                vd_reg[j+1] <= vd_reg[j];
            end
            mv_reg <= vd_reg[NS];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg <= in_frame;
            d1_reg <= in_dep;
            for (int k = 0; k < 3; k++) begin
                s1_reg[k] <= s_next[k];
                q2_reg[k] <= q_next[k];
            end
            f2_reg <= f1_reg;

            sd3_reg.ok    <= f2_reg && (q2_reg[2] > 48'sd0);
            sd3_reg.sgn_x <= q2_reg[0][47];
            sd3_reg.sgn_y <= q2_reg[1][47];
            mx3_reg       <= abs_x[46:0];
            my3_reg       <= abs_y[46:0];
            den3_reg      <= q2_reg[2][46:0];

            sd4_reg  <= sd3_reg;
            lox4_reg <= 43'(mx3_reg[23:0] * dtc_pkg::FX_HALF);
            hix4_reg <= 42'(mx3_reg[46:24] * dtc_pkg::FX_HALF);
            loy4_reg <= 43'(my3_reg[23:0] * dtc_pkg::FY_HALF);
            hiy4_reg <= 42'(my3_reg[46:24] * dtc_pkg::FY_HALF);
            dd4_reg  <= dd_next;

            // numerator times 1024, assembled from the partial products
            sdd_reg[0] <= sd4_reg;
            ddd_reg[0] <= dd4_reg;
            rx_reg[0]  <= ((RW'(hix4_reg) << 24) + RW'(lox4_reg)) << 10;
            ry_reg[0]  <= ((RW'(hiy4_reg) << 24) + RW'(loy4_reg)) << 10;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;

            // one quotient bit per stage, most significant first
            for (int j = 0; j < NS; j++) begin
                sdd_reg[j+1] <= sdd_reg[j];
                ddd_reg[j+1] <= ddd_reg[j];
                rx_reg[j+1]  <= sub_x[j][RW] ? rx_reg[j] : sub_x[j][RW-1:0];
                ry_reg[j+1]  <= sub_y[j][RW] ? ry_reg[j] : sub_y[j][RW-1:0];
                qx_reg[j+1]  <= {qx_reg[j][NS-2:0], !sub_x[j][RW]};
                qy_reg[j+1]  <= {qy_reg[j][NS-2:0], !sub_y[j][RW]};
            end

            md_reg <= odata_next;
            mu_reg <= sdd_reg[NS].ok;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    // an item flagged invalid carries zero coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("invalid item with nonzero coordinates");

    // a valid projection always has a nonzero denominator going into the divider
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && sd4_reg.ok |-> dd4_reg != '0)
        else $error("zero denominator on a valid item");

    // a stalled pipeline keeps its output item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed during stall");

endmodule : depth_to_color_pixel_registration

`default_nettype wire
